// ===== sv/srt_pkg.sv =====
// Shared types and constants for the segment reassembly tracker.
// Depends on nothing; every other file of the block imports it.
package srt_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int MAX_SEGMENTS_DEF  = 16;

    localparam logic [7:0]  HDR_RESET    = 8'd18;
    localparam logic [19:0] TOTAL_MAX    = 20'hFFFFF;
    localparam logic [4:0]  SEGCOUNT_MAX = 5'd31;

    // Result status codes.
    localparam logic [2:0] ST_PASS        = 3'd0;
    localparam logic [2:0] ST_PENDING     = 3'd1;
    localparam logic [2:0] ST_COMPLETE    = 3'd2;
    localparam logic [2:0] ST_INDEX_BIG   = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;
    localparam logic [2:0] ST_SHORT_LATER = 3'd5;
    localparam logic [2:0] ST_SHORT_MSG   = 3'd6;

    typedef struct packed {
        logic [7:0]  seq_number;
        logic [7:0]  segment_index;
        logic        more_flag;
        logic [15:0] segment_bytes;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  seq_out;
        logic [19:0] total_bytes;
        logic [4:0]  segment_total;
    } out_item_t;

    // Commands from the sequencer to the length accumulator.
    typedef struct packed {
        logic load;
        logic add;
    } acc_ctl_t;

endpackage

// ===== sv/srt_accum.sv =====
// Length accumulator of the segment reassembly tracker: one subtract, add and
// saturate step per cycle. Depends on srt_pkg.
module srt_accum
    import srt_pkg::*;
(
    input  logic        aclk,
    input  acc_ctl_t    ctl,
    input  logic [15:0] len_in,
    input  logic [7:0]  hdr_in,
    output logic [19:0] total_out,
    output logic        short_out
);

    logic [19:0] acc_reg;
    logic [19:0] acc_next;
    logic [15:0] payload;
    logic [20:0] sum;

    // A later segment contributes only its payload, so it must hold a full header.
    assign short_out = len_in < {8'd0, hdr_in};
    assign payload   = len_in - {8'd0, hdr_in};
    assign sum       = {1'b0, acc_reg} + {5'd0, payload};

    always_comb begin
        acc_next = acc_reg;
        if (ctl.load) begin
            acc_next = {4'd0, len_in};
        end else if (ctl.add) begin
            acc_next = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[19:0];
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign total_out = acc_reg;

endmodule

// ===== sv/segment_reassembly_tracker_top.sv =====
// Top level of the segment reassembly tracker: sequencer, entry table and
// length store. Depends on srt_pkg and srt_accum.

// Each input transfer carries one received segment header and gives exactly one
// result transfer. A segment shorter than the header, an unsegmented message
// and an index beyond the table's segment range are decided at once: such an
// item goes from idle straight to the result state. Any other segment walks the
// entry table through its single read port, one entry a cycle, stopping at the
// matching entry, and then passes through the update and completion check
// states. A segment that completes its message then sums the stored lengths
// through the one length store read port and the accumulator. A result still
// waiting downstream can hold an item back in the result state, and the input
// is not ready while one is in progress. The result sits in an output
// register, so a new item is taken while the previous result waits. The
// active bits are cleared by reset, so there is no clearing pass after reset.
// The user must write the header length register through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce it.
module segment_reassembly_tracker_top
    import srt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int LEN_DEPTH = 2 ** (EW + SW);
    localparam logic [EW-1:0] LAST_ENT  = EW'(TABLE_ENTRIES - 1);
    localparam logic [7:0]    SEG_LIMIT = 8'(MAX_SEGMENTS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_UPD  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    // Control and working registers.
    state_t                   state_reg, state_next;
    in_item_t                 item_reg, item_next;
    out_item_t                res_reg, res_next;
    out_item_t                out_reg, out_next;
    logic                     out_vld_reg, out_vld_next;
    logic [7:0]               hdr_reg, hdr_next;
    logic [TABLE_ENTRIES-1:0] active_reg, active_next;

    logic [EW-1:0]            ent_cnt_reg, ent_cnt_next;
    logic                     ent_done_reg, ent_done_next;
    logic [EW-1:0]            chk_idx_reg, chk_idx_next;
    logic                     chk_vld_reg, chk_vld_next;
    logic                     free_found_reg, free_found_next;
    logic [EW-1:0]            free_idx_reg, free_idx_next;
    logic [EW-1:0]            slot_reg, slot_next;

    logic [MAX_SEGMENTS-1:0]  mask_reg, mask_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            exp_reg, exp_next;
    logic                     last_reg, last_next;

    logic [SW-1:0]            sum_cnt_reg, sum_cnt_next;
    logic                     sum_done_reg, sum_done_next;
    logic [SW-1:0]            sum_idx_reg, sum_idx_next;
    logic                     sum_vld_reg, sum_vld_next;

    // Entry table, one word per entry, and the per-segment length store.
    logic [7:0]              seq_mem  [TABLE_ENTRIES];
    logic [MAX_SEGMENTS-1:0] mask_mem [TABLE_ENTRIES];
    logic [CW-1:0]           cnt_mem  [TABLE_ENTRIES];
    logic [CW-1:0]           exp_mem  [TABLE_ENTRIES];
    logic                    last_mem [TABLE_ENTRIES];
    logic [15:0]             len_mem  [LEN_DEPTH];

    logic [7:0]              seq_rd_reg;
    logic [MAX_SEGMENTS-1:0] mask_rd_reg;
    logic [CW-1:0]           cnt_rd_reg;
    logic [CW-1:0]           exp_rd_reg;
    logic                    last_rd_reg;
    logic [15:0]             len_rd_reg;

    logic                    meta_we;
    logic                    len_we;
    logic [EW+SW-1:0]        len_waddr;
    logic [EW+SW-1:0]        len_raddr;

    acc_ctl_t                acc_ctl;
    logic [19:0]             acc_total;
    logic                    acc_short;

    logic [SW-1:0]           idx_s;
    logic [CW-1:0]           idx_plus;
    logic [CW-1:0]           exp_last;
    logic [7:0]              exp_wide;
    logic                    hit;

    assign idx_s     = item_reg.segment_index[SW-1:0];
    assign idx_plus  = CW'(idx_s) + CW'(1);
    assign exp_last  = exp_reg - CW'(1);
    assign exp_wide  = 8'(exp_reg);
    assign hit       = active_reg[chk_idx_reg] && (seq_rd_reg == item_reg.seq_number);
    assign len_waddr = {slot_reg, idx_s};
    assign len_raddr = {slot_reg, sum_cnt_reg};

    srt_accum u_accum (
        .aclk      (aclk),
        .ctl       (acc_ctl),
        .len_in    (len_rd_reg),
        .hdr_in    (hdr_reg),
        .total_out (acc_total),
        .short_out (acc_short)
    );

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_vld_next    = out_vld_reg;
        hdr_next        = hdr_reg;
        active_next     = active_reg;
        ent_cnt_next    = ent_cnt_reg;
        ent_done_next   = ent_done_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        mask_next       = mask_reg;
        cnt_next        = cnt_reg;
        exp_next        = exp_reg;
        last_next       = last_reg;
        sum_cnt_next    = sum_cnt_reg;
        sum_done_next   = sum_done_reg;
        sum_idx_next    = sum_idx_reg;
        sum_vld_next    = sum_vld_reg;
        meta_we         = 1'b0;
        len_we          = 1'b0;
        acc_ctl         = '0;

        if (cfg_wr_en) begin
            hdr_next = cfg_wr_data;
        end

        // The downstream side drains the output register independently.
        if (out_vld_reg && m_ready) begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next              = s_data;
                    res_next.seq_out       = s_data.seq_number;
                    res_next.total_bytes   = '0;
                    res_next.segment_total = '0;
                    if (s_data.segment_bytes < {8'd0, hdr_reg}) begin
                        res_next.status = ST_SHORT_MSG;
                        state_next      = S_DONE;
                    end else if (!s_data.more_flag && (s_data.segment_index == 8'd0)) begin
                        res_next.status      = ST_PASS;
                        res_next.total_bytes = {4'd0, s_data.segment_bytes};
                        state_next           = S_DONE;
                    end else if (s_data.segment_index >= SEG_LIMIT) begin
                        res_next.status = ST_INDEX_BIG;
                        state_next      = S_DONE;
                    end else begin
                        ent_cnt_next    = '0;
                        ent_done_next   = 1'b0;
                        chk_vld_next    = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Issue one table read a cycle; its data is checked in the cycle after.
                chk_vld_next = !ent_done_reg;
                chk_idx_next = ent_cnt_reg;
                if (!ent_done_reg) begin
                    if (ent_cnt_reg == LAST_ENT) begin
                        ent_done_next = 1'b1;
                    end else begin
                        ent_cnt_next = ent_cnt_reg + EW'(1);
                    end
                end
                if (chk_vld_reg) begin
                    if (hit) begin
                        slot_next  = chk_idx_reg;
                        mask_next  = mask_rd_reg;
                        cnt_next   = cnt_rd_reg;
                        exp_next   = exp_rd_reg;
                        last_next  = last_rd_reg;
                        state_next = S_UPD;
                    end else begin
                        if (!active_reg[chk_idx_reg] && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (chk_idx_reg == LAST_ENT) begin
                            if (free_found_reg || !active_reg[chk_idx_reg]) begin
                                slot_next  = free_found_reg ? free_idx_reg : chk_idx_reg;
                                mask_next  = '0;
                                cnt_next   = '0;
                                exp_next   = '0;
                                last_next  = 1'b0;
                                state_next = S_UPD;
                            end else begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end
                        end
                    end
                end
            end

            S_UPD: begin
                // A duplicate keeps its stored length and count.
                if (!mask_reg[idx_s]) begin
                    mask_next[idx_s] = 1'b1;
                    cnt_next         = cnt_reg + CW'(1);
                    len_we           = 1'b1;
                    if (idx_plus > exp_reg) begin
                        exp_next = idx_plus;
                    end
                end
                if (!item_reg.more_flag) begin
                    last_next = 1'b1;
                end
                active_next[slot_reg] = 1'b1;
                state_next            = S_CHK;
            end

            S_CHK: begin
                if (last_reg && (cnt_reg == exp_reg)) begin
                    active_next[slot_reg] = 1'b0;
                    sum_cnt_next          = '0;
                    sum_done_next         = 1'b0;
                    sum_vld_next          = 1'b0;
                    state_next            = S_SUM;
                end else begin
                    meta_we         = 1'b1;
                    res_next.status = ST_PENDING;
                    state_next      = S_DONE;
                end
            end

            S_SUM: begin
                sum_vld_next = !sum_done_reg;
                sum_idx_next = sum_cnt_reg;
                if (!sum_done_reg) begin
                    if (CW'(sum_cnt_reg) == exp_last) begin
                        sum_done_next = 1'b1;
                    end else begin
                        sum_cnt_next = sum_cnt_reg + SW'(1);
                    end
                end
                if (sum_vld_reg) begin
                    if (sum_idx_reg == '0) begin
                        acc_ctl.load = 1'b1;
                        if (exp_last == '0) begin
                            state_next = S_FIN;
                        end
                    end else if (acc_short) begin
                        res_next.status = ST_SHORT_LATER;
                        state_next      = S_DONE;
                    end else begin
                        acc_ctl.add = 1'b1;
                        if (CW'(sum_idx_reg) == exp_last) begin
                            state_next = S_FIN;
                        end
                    end
                end
            end

            S_FIN: begin
                res_next.status        = ST_COMPLETE;
                res_next.total_bytes   = acc_total;
                res_next.segment_total = (exp_wide > {3'd0, SEGCOUNT_MAX}) ?
                                         SEGCOUNT_MAX : exp_wide[4:0];
                state_next             = S_DONE;
            end

            S_DONE: begin
                if (!out_vld_reg || m_ready) begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            out_vld_reg    <= 1'b0;
            hdr_reg        <= HDR_RESET;
            active_reg     <= '0;
            ent_cnt_reg    <= '0;
            ent_done_reg   <= 1'b0;
            chk_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            sum_cnt_reg    <= '0;
            sum_done_reg   <= 1'b0;
            sum_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_vld_reg    <= out_vld_next;
            hdr_reg        <= hdr_next;
            active_reg     <= active_next;
            ent_cnt_reg    <= ent_cnt_next;
            ent_done_reg   <= ent_done_next;
            chk_vld_reg    <= chk_vld_next;
            free_found_reg <= free_found_next;
            sum_cnt_reg    <= sum_cnt_next;
            sum_done_reg   <= sum_done_next;
            sum_vld_reg    <= sum_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        slot_reg     <= slot_next;
        mask_reg     <= mask_next;
        cnt_reg      <= cnt_next;
        exp_reg      <= exp_next;
        last_reg     <= last_next;
        sum_idx_reg  <= sum_idx_next;
    end

    // Entry table: written back when a message stays pending, read during the search.
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            seq_mem[slot_reg]  <= item_reg.seq_number;
            mask_mem[slot_reg] <= mask_reg;
            cnt_mem[slot_reg]  <= cnt_reg;
            exp_mem[slot_reg]  <= exp_reg;
            last_mem[slot_reg] <= last_reg;
        end
        seq_rd_reg  <= seq_mem[ent_cnt_reg];
        mask_rd_reg <= mask_mem[ent_cnt_reg];
        cnt_rd_reg  <= cnt_mem[ent_cnt_reg];
        exp_rd_reg  <= exp_mem[ent_cnt_reg];
        last_rd_reg <= last_mem[ent_cnt_reg];
    end

    // Length store, addressed by entry and segment index.
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= item_reg.segment_bytes;
        end
        len_rd_reg <= len_mem[len_raddr];
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    // Only one item is ever in progress.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item was in progress");

    // The entry being summed has already been released.
    a_sum_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM) |-> !active_reg[slot_reg])
        else $error("entry still active during length summation");

    // A completed message always counts at least one segment.
    a_complete_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_COMPLETE)) |-> (m_data.segment_total != 5'd0))
        else $error("complete result with no segments");

    // Only a passthrough or a completed message reports a length.
    a_total_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_PASS) && (m_data.status != ST_COMPLETE))
        |-> (m_data.total_bytes == 20'd0))
        else $error("length reported on a result that carries none");
`endif

endmodule
